/* hdl/lph_pkg.sv */
// shared constants and types for the linear probe hash set
`default_nettype none
package lph_pkg;

  localparam int SLOTS    = 1024;
  localparam int KEY_BITS = 64;

  localparam int KEY_W   = 64;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int TOTAL_W = 11;

  localparam int IDX_W  = $clog2(SLOTS);
  localparam int HALF   = SLOTS / 2;
  localparam int CNT_W  = $clog2(HALF + 1);
  localparam int WORD_W = KEY_BITS + 1;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_QUERY  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
  localparam logic [STAT_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_PROBE,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

/* hdl/linear_probe_hash_set_core.sv */
// linear probing hash set: one slot ram holding key and used mark, probe sequencer
// idle takes a beat; probe walks from its home slot to a hit or an empty slot; done then loads
// the output once it is free; an unused command skips probe; a clear sweeps every slot first
// probe rate is set by the single slot ram read port: one slot examined per cycle
// reset: synchronous; a sweep pass over every slot then clears every used mark, input stalled
// during it; the stored count resets to zero; new beats are taken only in idle
`default_nettype none
module linear_probe_hash_set_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [lph_pkg::CMD_W-1:0]     cmd,
  input  wire logic [lph_pkg::KEY_W-1:0]     key,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic                               found,
  output logic      [lph_pkg::STAT_W-1:0]    status,
  output logic      [lph_pkg::TOTAL_W-1:0]   entry_total
);

  lph_pkg::state_t state, state_next;

  logic [lph_pkg::CMD_W-1:0]    cmd_q;
  logic [lph_pkg::KEY_BITS-1:0] key_q;
  logic [lph_pkg::IDX_W-1:0]    probe_idx;
  logic [lph_pkg::IDX_W-1:0]    sweep_idx;
  logic [lph_pkg::CNT_W-1:0]    count;
  logic                         clr_pending;
  logic                         res_found;
  logic [lph_pkg::STAT_W-1:0]   res_status;

  logic                         wr_en;
  logic [lph_pkg::IDX_W-1:0]    wr_addr;
  logic [lph_pkg::WORD_W-1:0]   wr_data;
  logic [lph_pkg::IDX_W-1:0]    rd_addr;
  logic [lph_pkg::WORD_W-1:0]   rd_data;

  logic take_in;
  logic slot_used;
  logic slot_hit;
  logic has_room;
  logic sweep_last;
  logic out_free;
  logic do_store;
  logic probe_end;

  lph_ram #(
    .WIDTH(lph_pkg::WORD_W),
    .DEPTH(lph_pkg::SLOTS)
  ) u_slots (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  assign in_stall   = (state != lph_pkg::S_IDLE);
  assign take_in    = in_valid && !in_stall;
  assign slot_used  = rd_data[lph_pkg::KEY_BITS];
  assign slot_hit   = slot_used && (rd_data[lph_pkg::KEY_BITS-1:0] == key_q);
  assign has_room   = (count < lph_pkg::CNT_W'(lph_pkg::HALF));
  assign sweep_last = (sweep_idx == lph_pkg::IDX_W'(lph_pkg::SLOTS - 1));
  assign out_free   = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = probe_idx;
    wr_data    = {1'b1, key_q};
    do_store   = 1'b0;
    probe_end  = 1'b0;
    // next slot of the chain, or the home slot of a new beat
    rd_addr    = probe_idx + 1'b1;
    unique case (state)
      lph_pkg::S_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_idx;
        wr_data = '0;
        if (sweep_last) begin
          state_next = clr_pending ? lph_pkg::S_DONE : lph_pkg::S_IDLE;
        end
      end
      lph_pkg::S_IDLE: begin
        rd_addr = key[lph_pkg::IDX_W-1:0];
        if (take_in) begin
          unique case (cmd)
            lph_pkg::CMD_INSERT, lph_pkg::CMD_QUERY: state_next = lph_pkg::S_PROBE;
            lph_pkg::CMD_CLEAR: state_next = lph_pkg::S_SWEEP;
            default:            state_next = lph_pkg::S_DONE;
          endcase
        end
      end
      lph_pkg::S_PROBE: begin
        if (!slot_used || slot_hit) begin
          probe_end  = 1'b1;
          state_next = lph_pkg::S_DONE;
          if (!slot_used && cmd_q == lph_pkg::CMD_INSERT && has_room) begin
            do_store = 1'b1;
            wr_en    = 1'b1;
          end
        end
      end
      lph_pkg::S_DONE: begin
        if (out_free) begin
          state_next = lph_pkg::S_IDLE;
        end
      end
      default: state_next = lph_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lph_pkg::S_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_idx   <= '0;
      clr_pending <= 1'b0;
      count       <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (state == lph_pkg::S_SWEEP) begin
        sweep_idx <= sweep_idx + 1'b1;
      end
      if (take_in) begin
        cmd_q      <= cmd;
        key_q      <= key[lph_pkg::KEY_BITS-1:0];
        probe_idx  <= key[lph_pkg::IDX_W-1:0];
        res_found  <= 1'b0;
        res_status <= lph_pkg::ST_OK;
        if (cmd == lph_pkg::CMD_CLEAR) begin
          sweep_idx   <= '0;
          clr_pending <= 1'b1;
          count       <= '0;
        end else begin
          clr_pending <= 1'b0;
        end
      end
      if (state == lph_pkg::S_PROBE) begin
        if (!probe_end) begin
          probe_idx <= probe_idx + 1'b1;
        end else if (slot_hit) begin
          res_found  <= 1'b1;
          res_status <= (cmd_q == lph_pkg::CMD_INSERT) ? lph_pkg::ST_PRESENT : lph_pkg::ST_OK;
        end else if (cmd_q == lph_pkg::CMD_INSERT && !has_room) begin
          res_status <= lph_pkg::ST_FULL;
        end
      end
      if (do_store) begin
        count <= count + 1'b1;
      end
      // output register frees once the waiting beat is taken
      if (state == lph_pkg::S_DONE && out_free) begin
        out_valid   <= 1'b1;
        found       <= res_found;
        status      <= res_status;
        entry_total <= lph_pkg::TOTAL_W'(count);
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= lph_pkg::CNT_W'(lph_pkg::HALF))
    else $error("stored count above half the table");

  a_store_empty_only: assert property (@(posedge clk) disable iff (rst)
    (state == lph_pkg::S_PROBE && wr_en) |-> !slot_used)
    else $error("store into a used slot");

  a_query_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == lph_pkg::S_PROBE && cmd_q != lph_pkg::CMD_INSERT) |-> !wr_en)
    else $error("slot written by a non-insert beat");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |-> (count == $past(count) + 1'b1 || count == '0))
    else $error("stored count moved by more than one");

endmodule
`default_nettype wire

/* hdl/lph_ram.sv */
// generic single-clock ram, one write port and one registered read port
`default_nettype none
module lph_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* tb/linear_probe_hash_set_core_tb.sv */
// self-checking testbench for the linear probing hash set core
`timescale 1ns / 1ps
module linear_probe_hash_set_core_tb;
  import lph_pkg::*;

  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam logic [KEY_W-1:0] KEY_MASK   = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS);
  localparam int               RUN_LIMIT  = 10000000;
  localparam int               TAIL_WAIT  = 20;
  localparam int               POOL_DEPTH = 64;

  typedef struct packed {
    logic                found;
    logic [STAT_W-1:0]   status;
    logic [TOTAL_W-1:0]  total;
  } result_t;

  typedef struct packed {
    logic [CMD_W-1:0]    cmd;
    logic [KEY_W-1:0]    key;
    bit                  typed;
    logic                found;
    logic [STAT_W-1:0]   status;
    logic [TOTAL_W-1:0]  total;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [CMD_W-1:0]    cmd;
  logic [KEY_W-1:0]    key;
  logic                out_valid;
  logic                out_stall;
  logic                found;
  logic [STAT_W-1:0]   status;
  logic [TOTAL_W-1:0]  entry_total;

  // predictor state
  logic [KEY_W-1:0]    model_keys [SLOTS];
  bit                  model_used [SLOTS];
  int                  model_count;
  int                  model_refusals;
  logic [KEY_W-1:0]    key_pool [$];

  result_t             pending_results [$];
  result_t             head_result;
  int                  beats_in = 0;
  int                  beats_out = 0;
  int                  mismatches = 0;
  int                  cycle_count = 0;
  int                  send_idle_pct = 0;
  int                  recv_idle_pct = 0;

  // directed rows; untyped rows are checked against the predictor
  dir_row_t directed_rows [22] = '{
    '{CMD_QUERY,  64'h0000_0000_0000_0000, 1'b1, 1'b0, ST_OK,      11'd0},
    '{CMD_INSERT, 64'h0000_0000_0000_0000, 1'b1, 1'b0, ST_OK,      11'd1},
    '{CMD_INSERT, 64'h0000_0000_0000_0000, 1'b1, 1'b1, ST_PRESENT, 11'd1},
    '{CMD_QUERY,  64'h0000_0000_0000_0000, 1'b1, 1'b1, ST_OK,      11'd1},
    '{CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, ST_OK,      11'd2},
    '{CMD_INSERT, 64'h0000_0001_0000_03FF, 1'b0, 1'b0, ST_OK,      11'd0},
    '{CMD_QUERY,  64'h0000_0001_0000_03FF, 1'b0, 1'b0, ST_OK,      11'd0},
    '{CMD_INSERT, 64'h8000_0000_0000_0000, 1'b0, 1'b0, ST_OK,      11'd0},
    '{CMD_QUERY,  64'h7FFF_FFFF_FFFF_FFFF, 1'b0, 1'b0, ST_OK,      11'd0},
    '{CMD_UNUSED, 64'h0000_0000_0000_0000, 1'b1, 1'b0, ST_OK,      11'd4},
    '{CMD_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, ST_OK,      11'd4},
    '{CMD_QUERY,  64'hAAAA_AAAA_5555_5555, 1'b0, 1'b0, ST_OK,      11'd0},
    '{CMD_INSERT, 64'h5555_5555_AAAA_AAAA, 1'b0, 1'b0, ST_OK,      11'd0},
    '{CMD_INSERT, 64'hFFFF_FFFF_0000_0000, 1'b0, 1'b0, ST_OK,      11'd0},
    '{CMD_QUERY,  64'h0000_0000_FFFF_FFFF, 1'b0, 1'b0, ST_OK,      11'd0},
    '{CMD_QUERY,  64'hFFFF_FFFF_0000_0000, 1'b0, 1'b0, ST_OK,      11'd0},
    '{CMD_CLEAR,  64'h0000_0000_0000_0000, 1'b1, 1'b0, ST_OK,      11'd0},
    '{CMD_QUERY,  64'h0000_0000_0000_0000, 1'b1, 1'b0, ST_OK,      11'd0},
    '{CMD_QUERY,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, ST_OK,      11'd0},
    '{CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, ST_OK,      11'd1},
    '{CMD_QUERY,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1, ST_OK,      11'd1},
    '{CMD_CLEAR,  64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b0, ST_OK,      11'd0}
  };

  linear_probe_hash_set_core i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .cmd         (cmd),
    .key         (key),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .found       (found),
    .status      (status),
    .entry_total (entry_total)
  );

  always #2 clk = ~clk;

  // walks the probe chain and applies one item to the predicted set
  function automatic result_t hash_set_step(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k_in);
    result_t          r;
    logic [KEY_W-1:0] k;
    int               idx;
    int               where;
    bit               hit;
    bit               has_gap;
    k       = k_in & KEY_MASK;
    r       = '0;
    hit     = 1'b0;
    has_gap = 1'b0;
    where   = 0;
    idx     = int'(k[31:0] & 32'(SLOTS - 1));
    if (c == CMD_INSERT || c == CMD_QUERY) begin
      for (int n = 0; n < SLOTS && !hit && !has_gap; n++) begin
        if (!model_used[idx]) begin
          has_gap = 1'b1;
          where   = idx;
        end else if (model_keys[idx] == k) begin
          hit = 1'b1;
        end else begin
          idx = (idx + 1) % SLOTS;
        end
      end
    end
    if (c == CMD_INSERT) begin
      if (hit) begin
        r.found  = 1'b1;
        r.status = ST_PRESENT;
      end else if (model_count * 2 >= SLOTS || !has_gap) begin
        r.status = ST_FULL;
        model_refusals++;
      end else begin
        model_keys[where] = k;
        model_used[where] = 1'b1;
        model_count++;
        key_pool.push_back(k);
        if (key_pool.size() > POOL_DEPTH) void'(key_pool.pop_front());
      end
    end else if (c == CMD_QUERY) begin
      r.found = hit;
    end else if (c == CMD_CLEAR) begin
      foreach (model_used[i]) model_used[i] = 1'b0;
      model_count = 0;
    end
    r.total = TOTAL_W'(model_count);
    return r;
  endfunction

  // random key: clustered on a few home slots, reused from the pool, or fully random
  function automatic logic [KEY_W-1:0] pick_key(int hot_pct, int pool_pct);
    int               sel;
    logic [KEY_W-1:0] k;
    logic [IDX_W-1:0] hot;
    sel = $urandom_range(99);
    k   = {$urandom, $urandom};
    if (sel < hot_pct) begin
      case ($urandom_range(3))
        0:       hot = '0;
        1:       hot = '1;
        2:       hot = IDX_W'(SLOTS - 2);
        default: hot = IDX_W'(SLOTS / 3);
      endcase
      k[IDX_W-1:0] = hot;
    end else if (sel < hot_pct + pool_pct && key_pool.size() > 0) begin
      k = key_pool[$urandom_range(key_pool.size() - 1)];
      // near miss: same key but one bit off
      if ($urandom_range(3) == 0) k = k ^ (64'h1 << $urandom_range(KEY_W - 1));
    end
    return k & KEY_MASK;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch on %s at result beat %0d: got %0d, want %0d",
               what, beats_out, got, want);
  endtask

  task automatic send_item(logic [CMD_W-1:0] c, logic [KEY_W-1:0] k, bit typed,
                           result_t typed_res);
    result_t r;
    int      gap;
    int      start;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    r = hash_set_step(c, k);
    pending_results.push_back(typed ? typed_res : r);
    cmd      = c;
    key      = k;
    in_valid = 1'b1;
    start    = beats_in;
    do @(negedge clk); while (beats_in == start);
  endtask

  // hold the sender off until every pending result has come back
  task automatic drain_results();
    in_valid = 1'b0;
    do @(negedge clk); while (pending_results.size() != 0);
  endtask

  task automatic random_item(bit filling);
    int               r;
    logic [CMD_W-1:0] c;
    logic [KEY_W-1:0] k;
    r = $urandom_range(99);
    if ($urandom_range(99) == 0) drain_results();
    if (filling) begin
      c = (r < 92) ? CMD_INSERT : (r < 98) ? CMD_QUERY : CMD_UNUSED;
      k = pick_key(5, 5);
    end else begin
      c = (r < 55) ? CMD_INSERT : (r < 90) ? CMD_QUERY : (r < 94) ? CMD_CLEAR : CMD_UNUSED;
      k = pick_key(20, 30);
    end
    send_item(c, k, 1'b0, '0);
  endtask

  // receiver back-pressure
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // beat counting and result checking
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) beats_in++;
      if (out_valid !== 1'b0 && !out_stall) begin
        if (pending_results.size() == 0) begin
          report_mismatch("result with nothing pending", out_valid, 0);
        end else begin
          head_result = pending_results.pop_front();
          if (found !== head_result.found)
            report_mismatch("found", found, head_result.found);
          if (status !== head_result.status)
            report_mismatch("status", status, head_result.status);
          if (entry_total !== head_result.total)
            report_mismatch("entry_total", entry_total, head_result.total);
        end
        beats_out++;
      end
    end
  end

  initial begin
    int       n;
    dir_row_t row;
    rst            = 1'b1;
    in_valid       = 1'b0;
    cmd            = CMD_QUERY;
    key            = '0;
    out_stall      = 1'b0;
    model_count    = 0;
    model_refusals = 0;
    foreach (model_used[i]) model_used[i] = 1'b0;
    foreach (model_keys[i]) model_keys[i] = '0;
    repeat (6) @(negedge clk);
    rst = 1'b0;

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 21 : (ph == 1) ? 70 : 0;
      recv_idle_pct = (ph == 0) ? 70 : (ph == 1) ? 21 : 0;
      if (ph == 0) begin
        foreach (directed_rows[i]) begin
          row = directed_rows[i];
          send_item(row.cmd, row.key, row.typed, {row.found, row.status, row.total});
        end
        drain_results();
      end
      if (ph < 2) begin
        repeat (150) random_item(1'b0);
      end else begin
        // fill from empty until the half-full limit has refused a good number of inserts
        send_item(CMD_CLEAR, {$urandom, $urandom}, 1'b0, '0);
        n = 0;
        while (model_refusals < 30 && n < 2000) begin
          random_item(1'b1);
          n++;
        end
        repeat (150) random_item(1'b0);
      end
      drain_results();
    end

    repeat (TAIL_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hdl/lph_pkg.sv
hdl/lph_ram.sv
hdl/linear_probe_hash_set_core.sv
tb/linear_probe_hash_set_core_tb.sv
